FILE: src/krb_pkg.sv
// Package for the k-slack reorder buffer: entry, cell and control types.
// No dependencies; krb_cell, the top level and the testbench import it.
`default_nettype none

package krb_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] delay;
    logic [31:0] payload;
  } krb_entry_t;

  typedef struct packed {
    logic       valid;
    krb_entry_t data;
  } krb_cell_t;

  typedef struct packed {
    logic       shift;
    logic       insert;
    krb_entry_t item;
  } krb_ctrl_t;

endpackage

`default_nettype wire

FILE: src/krb_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing; used by the top level k_slack_reorder_buffer.
`default_nettype none

interface krb_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] stamp;
  logic [31:0] payload;

  modport source (output valid, output action, output stamp, output payload, input ready);
  modport sink   (input valid, input action, input stamp, input payload, output ready);
endinterface

interface krb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_stamp;
  logic [31:0] out_delay;
  logic [31:0] out_payload;
  logic        forced;
  logic        last;

  modport source (output valid, output out_stamp, output out_delay, output out_payload,
                  output forced, output last, input ready);
  modport sink   (input valid, input out_stamp, input out_delay, input out_payload,
                  input forced, input last, output ready);
endinterface

`default_nettype wire

FILE: src/krb_cell.sv
// One cell of the sorted chain: holds one buffered tuple and its valid bit.
// Depends on krb_pkg; shifts toward the head or makes room for a sorted insert.
`default_nettype none

module krb_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krb_pkg::krb_ctrl_t ctrl_i,
  input  krb_pkg::krb_cell_t left_i,
  input  logic              left_gt_i,
  input  krb_pkg::krb_cell_t right_i,
  output krb_pkg::krb_cell_t cell_o,
  output logic              gt_o
);
  import krb_pkg::*;

  logic       valid_q, valid_d;
  krb_entry_t data_q, data_d;

  assign gt_o   = !valid_q || (data_q.stamp > ctrl_i.item.stamp);
  assign cell_o = '{valid: valid_q, data: data_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end else if (ctrl_i.insert && gt_o) begin
      if (left_gt_i) begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
      end else begin
        valid_d = 1'b1;
        data_d  = ctrl_i.item;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

FILE: src/k_slack_reorder_buffer.sv
// K-slack reorder buffer: restores timestamp order with a chain of sorted cells.
// An input beat is taken while the block is idle; the sequencer then
// releases one tuple per cycle from the head cell (stalling while the output
// register is held), and an insert ends by putting the new tuple into the
// chain; a full chain first forces out its head tuple. The output register
// lets an input beat be taken while a result still waits.
// Depends on krb_pkg, krb_if and krb_cell.
`default_nettype none

module k_slack_reorder_buffer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        slack_we_i,
  input  logic [31:0] slack_i,
  krb_in_if.sink      in_i,
  krb_out_if.source   out_o
);
  import krb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic        state_q, state_d;
  logic [31:0] slack_q;
  logic [31:0] lt_q, lt_d;
  logic        act_q;
  krb_entry_t  item_q;

  logic        ovalid_q;
  krb_entry_t  odata_q;
  logic        oforced_q, olast_q;

  krb_cell_t   cell_w  [BUFFER_DEPTH];
  krb_cell_t   left_w  [BUFFER_DEPTH];
  krb_cell_t   right_w [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] gt_w, left_gt_w;
  krb_ctrl_t   ctrl;

  logic in_beat, out_free, want, pop, ins, done, forced, last;
  logic ripe0, ripe1;

  assign in_beat    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free   = !ovalid_q || out_o.ready;

  assign lt_d = (in_i.action == ACT_INSERT && in_i.stamp > lt_q) ? in_i.stamp : lt_q;

  assign ripe0 = cell_w[0].valid &&
                 (({1'b0, cell_w[0].data.stamp} + {1'b0, slack_q}) <= {1'b0, lt_q});
  assign ripe1 = cell_w[1].valid &&
                 (({1'b0, cell_w[1].data.stamp} + {1'b0, slack_q}) <= {1'b0, lt_q});

  always_comb begin
    want   = 1'b0;
    ins    = 1'b0;
    done   = 1'b0;
    forced = 1'b0;
    last   = 1'b0;
    if (state_q == ST_WORK) begin
      if (act_q == ACT_FLUSH) begin
        if (cell_w[0].valid) begin
          want = 1'b1;
          last = !cell_w[1].valid;
        end else begin
          done = 1'b1;
        end
      end else begin
        priority if (ripe0) begin
          want = 1'b1;
          last = !ripe1;
        end else if (cell_w[BUFFER_DEPTH-1].valid) begin
          want   = 1'b1;
          forced = 1'b1;
          last   = 1'b1;
        end else begin
          ins  = 1'b1;
          done = 1'b1;
        end
      end
    end
  end

  assign pop         = want && out_free;
  assign ctrl.shift  = pop;
  assign ctrl.insert = ins;
  assign ctrl.item   = item_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_beat) state_d = ST_WORK;
      ST_WORK: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i]    = '0;
      assign left_gt_w[i] = 1'b0;
    end else begin : g_body
      assign left_w[i]    = cell_w[i-1];
      assign left_gt_w[i] = gt_w[i-1];
    end
    if (i == BUFFER_DEPTH - 1) begin : g_tail
      assign right_w[i] = '0;
    end else begin : g_mid
      assign right_w[i] = cell_w[i+1];
    end

    krb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_w[i]),
      .left_gt_i (left_gt_w[i]),
      .right_i   (right_w[i]),
      .cell_o    (cell_w[i]),
      .gt_o      (gt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      slack_q  <= '0;
      lt_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (slack_we_i) begin
        slack_q <= slack_i;
      end
      if (in_beat) begin
        lt_q <= lt_d;
      end
      if (pop) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      act_q          <= in_i.action;
      item_q.stamp   <= in_i.stamp;
      item_q.payload <= in_i.payload;
      item_q.delay   <= lt_d - in_i.stamp;
    end
    if (pop) begin
      odata_q   <= cell_w[0].data;
      oforced_q <= forced;
      olast_q   <= last;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_stamp   = odata_q.stamp;
  assign out_o.out_delay   = odata_q.delay;
  assign out_o.out_payload = odata_q.payload;
  assign out_o.forced      = oforced_q;
  assign out_o.last        = olast_q;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for k_slack_reorder_buffer: directed and random timestamp streams with a
// queue-based sorted-buffer predictor, checked beat by beat on the result channel.
// Depends on krb_pkg, krb_if and the RTL of the block.

module testbench;
  import krb_pkg::*;

  localparam int Depth = 32;

  typedef struct {
    krb_entry_t ent;
    logic       forced;
    logic       last;
  } release_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        slack_we_i = 1'b0;
  logic [31:0] slack_i = '0;

  krb_in_if  in_bus();
  krb_out_if out_bus();

  k_slack_reorder_buffer #(.BUFFER_DEPTH(Depth)) dut (
    .clk_i,
    .rst_ni,
    .slack_we_i,
    .slack_i,
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #2 clk_i = ~clk_i;

  logic [31:0] slack_now = '0;
  logic [31:0] clock_now = '0;
  logic [31:0] stream_base;
  krb_entry_t  held[$];
  release_t    release_q[$];
  int          error_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_cycles = 0;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 25) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic predict_release(input logic act, input logic [31:0] st,
                                 input logic [31:0] pl);
    release_t   rel[$];
    release_t   r;
    krb_entry_t ent;
    logic [32:0] due;
    int         pos;
    if (act == ACT_FLUSH) begin
      while (held.size() > 0) begin
        r.ent = held.pop_front();
        r.forced = 1'b0;
        r.last = 1'b0;
        rel.push_back(r);
      end
    end else begin
      if (st > clock_now) clock_now = st;
      while (held.size() > 0) begin
        due = {1'b0, held[0].stamp} + {1'b0, slack_now};
        if (due > {1'b0, clock_now}) break;
        r.ent = held.pop_front();
        r.forced = 1'b0;
        r.last = 1'b0;
        rel.push_back(r);
      end
      if (held.size() >= Depth) begin
        r.ent = held.pop_front();
        r.forced = 1'b1;
        r.last = 1'b0;
        rel.push_back(r);
      end
      ent.stamp = st;
      ent.delay = clock_now - st;
      ent.payload = pl;
      pos = held.size();
      while (pos > 0 && held[pos-1].stamp > st) pos--;
      held.insert(pos, ent);
    end
    if (rel.size() > 0) rel[rel.size()-1].last = 1'b1;
    foreach (rel[i]) release_q.push_back(rel[i]);
  endtask

  task automatic send_beat(input logic act, input logic [31:0] st, input logic [31:0] pl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.stamp   <= st;
    in_bus.payload <= pl;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_release(act, st, pl);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    end_burst();
    while (release_q.size() > 0) @(negedge clk_i);
    // let a trailing insert that releases nothing settle
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_slack(input logic [31:0] value);
    wait_drained();
    slack_we_i <= 1'b1;
    slack_i    <= value;
    @(negedge clk_i);
    slack_we_i <= 1'b0;
    slack_now = value;
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_bus.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    release_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (release_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected, stamp %h",
                                  out_bus.out_stamp));
      end else begin
        want = release_q.pop_front();
        if (out_bus.out_stamp !== want.ent.stamp)
          report_mismatch($sformatf("out_stamp %h, want %h", out_bus.out_stamp,
                                    want.ent.stamp));
        if (out_bus.out_delay !== want.ent.delay)
          report_mismatch($sformatf("out_delay %h, want %h", out_bus.out_delay,
                                    want.ent.delay));
        if (out_bus.out_payload !== want.ent.payload)
          report_mismatch($sformatf("out_payload %h, want %h", out_bus.out_payload,
                                    want.ent.payload));
        if (out_bus.forced !== want.forced)
          report_mismatch($sformatf("forced %b, want %b (stamp %h)", out_bus.forced,
                                    want.forced, want.ent.stamp));
        if (out_bus.last !== want.last)
          report_mismatch($sformatf("last %b, want %b (stamp %h)", out_bus.last,
                                    want.last, want.ent.stamp));
      end
    end
  end

  task automatic test_ordering();
    write_slack(32'd100);
    send_beat(ACT_FLUSH, $urandom, $urandom);
    send_beat(ACT_INSERT, 32'd0, 32'h0000_0000);
    send_beat(ACT_INSERT, 32'd50, 32'h0000_00a1);
    send_beat(ACT_INSERT, 32'd50, 32'h0000_00b2);
    send_beat(ACT_INSERT, 32'd50, 32'h0000_00c3);
    send_beat(ACT_INSERT, 32'd20, 32'h0000_00d4);
    send_beat(ACT_INSERT, 32'd120, 32'h0000_00e5);
    send_beat(ACT_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(ACT_FLUSH, 32'd0, 32'd0);
    send_beat(ACT_INSERT, 32'd130, 32'hffff_ffff);
    write_slack(32'd0);
    send_beat(ACT_INSERT, 32'd131, 32'h5a5a_a5a5);
    send_beat(ACT_INSERT, 32'd125, 32'ha5a5_5a5a);
    send_beat(ACT_FLUSH, 32'd0, 32'd0);
    end_burst();
  endtask

  task automatic test_buffer_full();
    int k;
    write_slack(32'hffff_ffff);
    for (k = 0; k < Depth + 4; k++)
      send_beat(ACT_INSERT, clock_now + $urandom_range(20), $urandom);
    send_beat(ACT_FLUSH, $urandom, $urandom);
    end_burst();
  endtask

  task automatic run_stream(input int count, input int src_pct, input int sink_pct);
    int          k;
    int          pick;
    logic [31:0] st;
    logic [31:0] prev_st;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    prev_st = stream_base;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_beat(ACT_FLUSH, $urandom, $urandom);
      end else begin
        if (pick < 12) begin
          st = $urandom_range(clock_now, 0);
        end else if (pick < 20) begin
          st = prev_st;
        end else begin
          stream_base = stream_base + $urandom_range(6);
          st = stream_base - $urandom_range(60);
        end
        prev_st = st;
        send_beat(ACT_INSERT, st, $urandom);
      end
    end
    end_burst();
  endtask

  task automatic test_random_streams();
    stream_base = clock_now + 32'd100;
    write_slack(32'd8);
    run_stream(55, 0, 0);
    write_slack(32'd40);
    run_stream(55, 46, 0);
    write_slack(32'd200);
    run_stream(55, 0, 46);
    write_slack($urandom_range(100, 1));
    run_stream(55, 12, 12);
    write_slack(32'd0);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_beat(ACT_FLUSH, $urandom, $urandom);
    end_burst();
  endtask

  task automatic test_backpressure();
    int k;
    write_slack(32'd0);
    hold_cycles = 300;
    for (k = 0; k < 45; k++)
      send_beat(ACT_INSERT, clock_now + $urandom_range(3), $urandom);
    wait_drained();
    for (k = 0; k < 5; k++)
      send_beat(ACT_INSERT, clock_now + $urandom_range(3), $urandom);
    send_beat(ACT_FLUSH, $urandom, $urandom);
    end_burst();
  endtask

  task automatic test_stamp_ceiling();
    int k;
    write_slack(32'hffff_ffff);
    send_beat(ACT_INSERT, 32'd0, 32'd0);
    send_beat(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    for (k = 0; k < 20; k++) send_beat(ACT_INSERT, $urandom, $urandom);
    write_slack($urandom);
    src_idle_pct = 12;
    sink_stall_pct = 12;
    for (k = 0; k < 20; k++) send_beat(ACT_INSERT, $urandom, $urandom);
    write_slack(32'd0);
    for (k = 0; k < 5; k++) send_beat(ACT_INSERT, $urandom, $urandom);
    send_beat(ACT_INSERT, 32'hffff_ffff, 32'h0f0f_f0f0);
    send_beat(ACT_FLUSH, 32'd0, 32'd0);
    end_burst();
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.action  = ACT_INSERT;
    in_bus.stamp   = '0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_ordering();
    test_buffer_full();
    test_random_streams();
    test_backpressure();
    test_stamp_ceiling();
    while (release_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/krb_pkg.sv
src/krb_if.sv
src/krb_cell.sv
src/k_slack_reorder_buffer.sv
dv/testbench.sv
